// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg
// Types and decode constants of the card reader command sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crs_pkg;

  // Event codes
  localparam logic [2:0] OP_COMMAND    = 3'd0;
  localparam logic [2:0] OP_XFER_DONE  = 3'd1;
  localparam logic [2:0] OP_FEED_TIMER = 3'd2;
  localparam logic [2:0] OP_START_KEY  = 3'd3;
  localparam logic [2:0] OP_RUNOUT     = 3'd4;
  localparam logic [2:0] OP_PANEL      = 3'd5;

  // Command classes (low three bits of the command byte)
  localparam logic [2:0] CC_TEST  = 3'd0;
  localparam logic [2:0] CC_WRITE = 3'd1;
  localparam logic [2:0] CC_READ  = 3'd2;
  localparam logic [2:0] CC_FEED  = 3'd3;
  localparam logic [2:0] CC_SENSE = 3'd4;

  // Command byte patterns
  localparam logic [7:0] CMD_WRITE    = 8'h25;
  localparam logic [5:0] CMD_XFER_LO6 = 6'h25;
  localparam logic [7:0] MASK_DF      = 8'hDF;
  localparam logic [7:0] PAT_READ_C2  = 8'hC2;
  localparam logic [5:0] PAT_READ_LO6 = 6'h02;
  localparam logic [7:0] CMD_READ_D2  = 8'hD2;
  localparam logic [5:0] PAT_FEED_LO6 = 6'h23;
  localparam logic [7:0] CMD_NOP      = 8'h03;
  localparam logic [1:0] STK_INVALID  = 2'd3;
  localparam logic [3:0] PAT_SENSE    = 4'h4;

  // Status bit positions
  localparam int unsigned ST_CE = 0;
  localparam int unsigned ST_DE = 1;
  localparam int unsigned ST_UC = 2;
  localparam int unsigned ST_UE = 3;

  // Sense bit positions
  localparam int unsigned SN_REJ = 0;
  localparam int unsigned SN_INT = 1;
  localparam int unsigned SN_DAT = 4;

  // Timer requests
  localparam logic [1:0] TMR_NONE   = 2'd0;
  localparam logic [1:0] TMR_FEED   = 2'd1;
  localparam logic [1:0] TMR_RUNOUT = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  command_byte;
    logic [11:0] hopper_before;
    logic        column_error;
    logic        attention;
    logic        stop_request;
    logic        eof_request;
  } crs_cmd_t;

  typedef struct packed {
    logic       channel_end;
    logic       device_end;
    logic       unit_check;
    logic       unit_exception;
    logic [5:0] sense_bits;
    logic       busy_res;
    logic       command_done;
    logic       service_request;
    logic       reader_ready;
    logic [1:0] timer_start;
    logic       card_stacked;
    logic [1:0] stacker_number;
  } crs_res_t;

  typedef struct packed {
    logic [5:0]  sense;
    logic [3:0]  status;
    logic        busy;
    logic        done;
    logic        request;
    logic [7:0]  cur_cmd;
    logic        card_in_feed;
    logic        ready;
    logic [1:0]  stacker;
    logic [11:0] hopper;
    logic        eof;
    logic        stop;
  } crs_state_t;

endpackage

// ===== sv/crs_cmd_if.sv =====
// ----------------------------------------------------------------------------
// crs_cmd_if
// Valid/ready channel carrying one event item into the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crs_cmd_if;
  import crs_pkg::*;

  logic     valid;
  logic     ready;
  crs_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/crs_res_if.sv =====
// ----------------------------------------------------------------------------
// crs_res_if
// Valid/ready channel carrying one result item out of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crs_res_if;
  import crs_pkg::*;

  logic     valid;
  logic     ready;
  crs_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/card_reader_command_sequencer_core.sv =====
// Registers: an accepted item passes the input register, then the result
// register. Throughput: one item per cycle while the result is not stalled;
// the state update is one pass of decode logic.
// Reset (rst, synchronous) clears all sequencer state and both valid flags.
// A stalled result holds while the input register still takes one item.
// ----------------------------------------------------------------------------
// card_reader_command_sequencer_core
// Card reader control unit: decodes channel commands and reader events,
// tracks sense, status, feed and hopper state, reports timers and stacking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module card_reader_command_sequencer_core #(
  parameter int HOPPER_MAX = 4095
) (
  input logic         clk,
  input logic         rst,
  crs_cmd_if.sink     cmd,
  crs_res_if.source   res
);
  import crs_pkg::*;

  logic       item_valid;
  crs_cmd_t   item;
  logic       advance;
  crs_state_t st;
  crs_state_t st_next;
  crs_res_t   step_res;

  // Held item moves on when the result register is free or draining
  assign advance = item_valid && (!res.valid || res.ready);

  crs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  crs_step #(
    .HOPPER_MAX (HOPPER_MAX)
  ) u_step (
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (step_res)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (!res.valid || res.ready) begin
      res.valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.data <= step_res;
    end
  end
endmodule

// ===== sv/crs_in_reg.sv =====
// ----------------------------------------------------------------------------
// crs_in_reg
// Input register: captures one event item and holds it until it advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_in_reg (
  input  logic              clk,
  input  logic              rst,
  crs_cmd_if.sink           cmd,
  input  logic              advance,
  output logic              item_valid,
  output crs_pkg::crs_cmd_t item
);
  import crs_pkg::*;

  // Take a new item when empty or when the held one moves on
  assign cmd.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item <= cmd.data;
    end
  end
endmodule

// ===== sv/crs_step.sv =====
// ----------------------------------------------------------------------------
// crs_step
// Event decode: next sequencer state and the result item for one event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crs_step #(
  parameter int HOPPER_MAX = 4095
) (
  input  crs_pkg::crs_state_t st,
  input  crs_pkg::crs_cmd_t   item,
  output crs_pkg::crs_state_t st_next,
  output crs_pkg::crs_res_t   res
);
  import crs_pkg::*;

  logic [11:0] hb;
  logic        xfer_ce;
  logic        xfer_both;

  // Hopper count clamps at the configured maximum
  always_comb begin
    if ({4'd0, item.hopper_before} > 16'(HOPPER_MAX)) begin
      hb = 12'(HOPPER_MAX);
    end else begin
      hb = item.hopper_before;
    end
  end

  // Transfer end is decided on the held command
  assign xfer_ce   = (st.cur_cmd[5:0] == CMD_XFER_LO6);
  assign xfer_both = !xfer_ce && ((st.cur_cmd & MASK_DF) == PAT_READ_C2);

  always_comb begin
    crs_state_t n;
    logic [7:0] cb;
    logic [1:0] timer;
    logic       stacked;
    logic [1:0] stk;

    n       = st;
    cb      = item.command_byte;
    timer   = TMR_NONE;
    stacked = 1'b0;
    stk     = 2'd0;

    unique case (item.opcode)
      OP_COMMAND: begin
        n.status = 4'd0;
        unique case (cb[2:0])
          CC_TEST: begin
            if (!st.ready) n.sense[SN_INT] = 1'b1;
            if (cb != 8'd0) n.sense[SN_REJ] = 1'b1;
            if (n.sense != 6'd0) n.status[ST_UC] = 1'b1;
          end
          CC_WRITE: begin
            n.sense[SN_INT] = 1'b1;
            if (cb != CMD_WRITE) begin
              n.sense[SN_REJ] = 1'b1;
              n.status[ST_UC] = 1'b1;
            end else begin
              n.cur_cmd = cb;
              n.done    = 1'b0;
              n.busy    = 1'b1;
            end
          end
          CC_READ: begin
            n.sense = st.sense & 6'(1 << SN_INT);
            if (cb[5:0] != PAT_READ_LO6 && cb != CMD_READ_D2) begin
              n.sense[SN_REJ] = 1'b1;
              n.status[ST_UC] = 1'b1;
            end else if (!st.ready) begin
              n.sense[SN_INT] = 1'b1;
              n.status[ST_UC] = 1'b1;
            end else begin
              if (item.column_error) n.sense[SN_DAT] = 1'b1;
              if (cb[7:6] != STK_INVALID) n.stacker = cb[7:6];
              n.cur_cmd = cb;
              n.done    = 1'b0;
              n.busy    = 1'b1;
            end
          end
          CC_FEED: begin
            n.sense = st.sense & 6'(1 << SN_INT);
            if (cb == CMD_NOP) begin
              n.cur_cmd       = cb;
              n.done          = 1'b1;
              n.status[ST_CE] = 1'b1;
              n.status[ST_DE] = 1'b1;
            end else if (cb[5:0] != PAT_FEED_LO6 || !st.ready
                         || cb[7:6] == STK_INVALID) begin
              if (cb[5:0] == PAT_FEED_LO6 && !st.ready) n.sense[SN_INT] = 1'b1;
              else n.sense[SN_REJ] = 1'b1;
              n.status[ST_UC] = 1'b1;
            end else begin
              n.stacker       = cb[7:6];
              n.busy          = 1'b1;
              n.status[ST_CE] = 1'b1;
              n.done          = xfer_ce || xfer_both;
              if (xfer_both) n.status[ST_DE] = 1'b1;
              if (!xfer_ce && !xfer_both) timer = TMR_FEED;
            end
          end
          CC_SENSE: begin
            if (cb[3:0] != PAT_SENSE) begin
              n.sense         = 6'(1 << SN_REJ) | (st.sense & 6'(1 << SN_INT));
              n.status[ST_UC] = 1'b1;
            end else begin
              n.cur_cmd = cb;
              n.done    = 1'b0;
            end
          end
          default: begin
            n.sense[SN_REJ] = 1'b1;
            n.status[ST_UC] = 1'b1;
          end
        endcase
      end

      OP_XFER_DONE: begin
        n.status[ST_CE] = 1'b1;
        if (xfer_ce || xfer_both) n.done = 1'b1;
        if (xfer_both) n.status[ST_DE] = 1'b1;
        if (!xfer_ce && !xfer_both) timer = TMR_FEED;
      end

      OP_FEED_TIMER: begin
        n.status[ST_DE] = 1'b1;
        n.busy          = 1'b0;
        n.done          = 1'b1;
        n.request       = 1'b1;
        if (st.sense != 6'd0) n.status[ST_UC] = 1'b1;
        if (st.card_in_feed) begin
          stacked        = 1'b1;
          stk            = st.stacker;
          n.card_in_feed = 1'b0;
        end
        if (st.hopper == 12'd0 && st.eof) begin
          n.status[ST_UE] = 1'b1;
          n.eof           = 1'b0;
        end else if (!st.stop) begin
          // Pick the next card
          n.card_in_feed = (hb != 12'd0);
          n.hopper       = (hb != 12'd0) ? hb - 12'd1 : 12'd0;
          n.ready        = n.card_in_feed && !(n.hopper == 12'd0 && !st.eof);
        end else begin
          n.ready = 1'b0;
          n.stop  = 1'b0;
        end
      end

      OP_START_KEY: begin
        if (st.card_in_feed && !st.eof) begin
          timer = TMR_RUNOUT;
        end else if (hb == 12'd0) begin
          n.sense[SN_INT] = 1'b1;
          n.ready         = 1'b0;
        end else begin
          if (!st.stop) begin
            n.card_in_feed = 1'b1;
            n.hopper       = hb - 12'd1;
            n.ready        = !(n.hopper == 12'd0 && !st.eof);
            if (n.ready && item.attention) begin
              n.status  = 4'(1 << ST_DE);
              n.request = 1'b1;
              n.done    = 1'b1;
            end
          end else begin
            n.ready = 1'b0;
          end
          n.stop          = 1'b0;
          n.sense[SN_INT] = !n.ready;
        end
      end

      OP_RUNOUT: begin
        if (st.card_in_feed) begin
          stacked        = 1'b1;
          n.card_in_feed = 1'b0;
        end
        if (st.hopper != 12'd0 && !st.stop) begin
          n.card_in_feed = (hb != 12'd0);
          n.hopper       = (hb != 12'd0) ? hb - 12'd1 : 12'd0;
          timer          = TMR_RUNOUT;
        end
      end

      OP_PANEL: begin
        if (item.stop_request) n.stop = 1'b1;
        if (item.eof_request) n.eof = 1'b1;
      end

      default: begin
      end
    endcase

    st_next = n;

    // Result shows the state after the event
    res.channel_end     = n.status[ST_CE];
    res.device_end      = n.status[ST_DE];
    res.unit_check      = n.status[ST_UC];
    res.unit_exception  = n.status[ST_UE];
    res.sense_bits      = n.sense;
    res.busy_res        = n.busy;
    res.command_done    = n.done;
    res.service_request = n.request;
    res.reader_ready    = n.ready;
    res.timer_start     = timer;
    res.card_stacked    = stacked;
    res.stacker_number  = stk;
  end
endmodule

// ===== sv/crs_checker.sv =====
// ----------------------------------------------------------------------------
// crs_checker
// Port-level checks on the result channel of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crs_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input crs_pkg::crs_res_t out_data
);
  import crs_pkg::*;

  // Timer request is never the unused code
  `ASSERT_IMPLIES(a_timer_code, clk, rst, out_valid, out_data.timer_start != 2'd3, "bad timer code")

  // A stacker number only comes with a stacked card
  `ASSERT_IMPLIES(a_stk_only_stacked, clk, rst, out_valid && !out_data.card_stacked, out_data.stacker_number == 2'd0, "stacker without card")

  // Stacking never coincides with a feed timer request
  `ASSERT_IMPLIES(a_stack_no_feed, clk, rst, out_valid && out_data.card_stacked, out_data.timer_start != TMR_FEED, "stack with feed timer")

  // End of file status always carries device end
  `ASSERT_IMPLIES(a_ue_has_de, clk, rst, out_valid && out_data.unit_exception, out_data.device_end, "exception without device end")

  // A stalled result stays offered
  `ASSERT_NEXT(a_valid_holds, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
endmodule

bind card_reader_command_sequencer_core crs_checker u_crs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_data  (res.data)
);
